>>> hdl/pcse_pkg.sv
// ----------------------------------------------------------------------------
// pcse_pkg
// Shared types and constants for the PCI type-0 configuration space emulator.
// ----------------------------------------------------------------------------
`default_nettype none

package pcse_pkg;

  localparam int SPACE_BYTES = 256;
  localparam int ADDR_W      = $clog2(SPACE_BYTES);
  localparam int CHK_W       = 14;
  localparam int NUM_BARS    = 6;
  localparam int IDX_W       = 3;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 40;

  localparam logic [7:0] OFS_COMMAND    = 8'h04;
  localparam logic [7:0] OFS_CACHE_LINE = 8'h0C;
  localparam logic [7:0] OFS_LATENCY    = 8'h0D;
  localparam logic [7:0] OFS_BAR_FIRST  = 8'h10;
  localparam logic [7:0] OFS_BAR_LAST   = 8'h24;
  localparam logic [7:0] OFS_INT_LINE   = 8'h3C;

  localparam logic [31:0] COMMAND_KEEP = 32'h0000_0007;
  localparam logic [31:0] PROBE_VALUE  = 32'hFFFF_FFFF;
  localparam logic [3:0]  TYPE_BITS    = 4'hF;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_LOAD  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_READ,
    OP_WRITE,
    OP_PROBE
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_REQ,
    ST_RD_CAP,
    ST_PR_REQ,
    ST_PR_CAP,
    ST_WR,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

>>> hdl/pcse_ram.sv
// ----------------------------------------------------------------------------
// pcse_ram
// Single-port byte store with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pcse_ram #(
  parameter int ADDR_W = 8,
  parameter int DATA_W = 8
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] addr,
  input  wire logic [DATA_W-1:0] wdata,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

>>> hdl/pci_config_space_emulator_unit.sv
// ----------------------------------------------------------------------------
// pci_config_space_emulator_unit
// Shadow PCI type-0 configuration space with guest read, filtered write and
// unfiltered load commands.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one access word: cmd, offset, access_size, write_data.
//   m_axis returns one result word per access: read_data and status.
//   cfg_we/cfg_index/cfg_data load the BAR sizes (index 3 is the VM memory
//   size reported for BAR3); write them only while the block is idle.
// Sequence: a read steps through an address state and a capture state for
//   each byte; a write or load writes one byte per cycle; a BAR size probe
//   reads the type bits, then does four byte writes; an error, n = 0, an
//   ignored write or a no-op goes straight to the result state.
//   The byte store has one port. One access is in flight at a time.
// Reset: a clearing pass writes zero to all 256 bytes, one per cycle, with
//   s_axis_tready low throughout. BAR sizes reset to zero.
// Stall: the result waits in the output register; the next access is taken
//   meanwhile, and its result waits until the register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module pci_config_space_emulator_unit
  import pcse_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  // [1:0] cmd, [9:2] offset, [12:10] access_size, [44:13] write_data
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // [31:0] read_data, [32] status
  output logic      [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  input  wire logic                   cfg_we,
  input  wire logic [IDX_W-1:0]       cfg_index,
  input  wire logic [31:0]            cfg_data
);

  state_t state, state_next;

  logic [31:0]       bar_len [NUM_BARS];
  logic [ADDR_W-1:0] clr_cnt;
  logic [ADDR_W-1:0] base;
  logic [2:0]        cnt;
  logic [2:0]        nbytes;
  logic [31:0]       wdata;
  logic [31:0]       acc;
  logic              err;
  logic [31:0]       out_rd;
  logic              out_st;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [7:0]        ram_wdata;
  logic [7:0]        ram_q;

  cmd_t        in_cmd;
  logic [7:0]  in_ofs;
  logic [2:0]  in_size;
  logic [31:0] in_data;
  logic [2:0]  in_n;
  logic        in_oor;
  logic [IDX_W-1:0] in_bar;
  logic        in_is_bar;
  op_t         in_op;
  logic [31:0] in_val;

  logic accept;
  logic last;
  logic out_load;

  assign in_cmd  = cmd_t'(s_axis_tdata[1:0]);
  assign in_ofs  = s_axis_tdata[9:2];
  assign in_size = s_axis_tdata[12:10];
  assign in_data = s_axis_tdata[44:13];

  assign in_n      = in_size[2] ? 3'd4 : in_size;
  assign in_oor    = (CHK_W'(in_ofs) + CHK_W'(in_n)) > CHK_W'(SPACE_BYTES);
  assign in_bar    = IDX_W'(in_ofs[5:2] - 4'd4);
  assign in_is_bar = (in_ofs >= OFS_BAR_FIRST) && (in_ofs <= OFS_BAR_LAST)
                     && (in_ofs[1:0] == 2'b00);

  always_comb begin
    in_op  = OP_NONE;
    in_val = in_data;
    if (!in_oor) begin
      unique case (in_cmd)
        CMD_READ: begin
          in_op = (in_n != 3'd0) ? OP_READ : OP_NONE;
        end
        CMD_WRITE: begin
          if (in_ofs == OFS_COMMAND) begin
            in_op  = OP_WRITE;
            in_val = in_data & COMMAND_KEEP;
          end else if (in_ofs == OFS_INT_LINE || in_ofs == OFS_CACHE_LINE ||
                       in_ofs == OFS_LATENCY) begin
            in_op = OP_WRITE;
          end else if (in_is_bar) begin
            if (in_data == PROBE_VALUE) begin
              in_val = bar_len[in_bar];
              in_op  = (bar_len[in_bar] != 32'd0) ? OP_PROBE : OP_NONE;
            end else begin
              in_op = OP_WRITE;
            end
          end
          if (in_op == OP_WRITE && in_n == 3'd0) begin
            in_op = OP_NONE;
          end
        end
        CMD_LOAD: begin
          in_op = (in_n != 3'd0) ? OP_WRITE : OP_NONE;
        end
        default: begin
          in_op = OP_NONE;
        end
      endcase
    end
  end

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign last     = (3'(cnt + 3'd1) == nbytes);
  assign out_load = (state == ST_DONE) && (!m_axis_tvalid || m_axis_tready);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_cnt == ADDR_W'(SPACE_BYTES - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          unique case (in_op)
            OP_READ:  state_next = ST_RD_REQ;
            OP_WRITE: state_next = ST_WR;
            OP_PROBE: state_next = ST_PR_REQ;
            default:  state_next = ST_DONE;
          endcase
        end
      end
      ST_RD_REQ: state_next = ST_RD_CAP;
      ST_RD_CAP: state_next = last ? ST_DONE : ST_RD_REQ;
      ST_PR_REQ: state_next = ST_PR_CAP;
      ST_PR_CAP: state_next = ST_WR;
      ST_WR:     state_next = last ? ST_DONE : ST_WR;
      ST_DONE: begin
        if (out_load) state_next = ST_IDLE;
      end
      default:   state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    ram_we        = 1'b0;
    ram_addr      = base + ADDR_W'(cnt);
    ram_wdata     = wdata[7:0];
    unique case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_cnt;
        ram_wdata = 8'h00;
      end
      ST_IDLE:  s_axis_tready = 1'b1;
      ST_WR:    ram_we = 1'b1;
      default:  ram_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      clr_cnt       <= '0;
      m_axis_tvalid <= 1'b0;
      for (int i = 0; i < NUM_BARS; i++) bar_len[i] <= 32'd0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_cnt <= ADDR_W'(clr_cnt + 1'b1);
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (cfg_we && cfg_index < IDX_W'(NUM_BARS)) begin
        bar_len[cfg_index] <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      base   <= ADDR_W'(in_ofs);
      nbytes <= in_n;
      cnt    <= 3'd0;
      acc    <= 32'd0;
      err    <= in_oor;
      wdata  <= in_val;
    end
    unique case (state)
      ST_RD_CAP: begin
        acc[cnt[1:0]*8 +: 8] <= ram_q;
        cnt                  <= 3'(cnt + 3'd1);
      end
      ST_PR_REQ: wdata <= ~(wdata - 32'd1);
      ST_PR_CAP: begin
        wdata[3:0] <= wdata[3:0] | (ram_q[3:0] & TYPE_BITS);
        cnt        <= 3'd0;
        nbytes     <= 3'd4;
      end
      ST_WR: begin
        wdata <= {8'h00, wdata[31:8]};
        cnt   <= 3'(cnt + 3'd1);
      end
      default: ;
    endcase
    if (out_load) begin
      out_rd <= acc;
      out_st <= err;
    end
  end

  assign m_axis_tdata = {7'd0, out_st, out_rd};

  pcse_ram #(
    .ADDR_W (ADDR_W),
    .DATA_W (8)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_q)
  );

endmodule

`default_nettype wire

>>> hdl/pcse_checker.sv
// ----------------------------------------------------------------------------
// pcse_checker
// Port-level checks for the configuration space emulator, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module pcse_checker
  import pcse_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input wire logic                   s_axis_tvalid,
  input wire logic                   s_axis_tready,
  input wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input wire logic                   m_axis_tvalid,
  input wire logic                   m_axis_tready
);

  logic [9:0] span;

  assign span = 10'(s_axis_tdata[9:2]) +
                (s_axis_tdata[12] ? 10'd4 : 10'(s_axis_tdata[11:10]));

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second word taken while an access is in flight");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[32] |-> m_axis_tdata[31:0] == 32'd0)
    else $error("error result carries read data");

  a_oor_fast: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && span > 10'(SPACE_BYTES) && !m_axis_tvalid
    |=> ##1 m_axis_tvalid && m_axis_tdata[32])
    else $error("out-of-range access not reported");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid && !s_axis_tready)
    else $error("block active right after reset");

endmodule

bind pci_config_space_emulator_unit pcse_checker u_pcse_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);

`default_nettype wire
